// ===== rtl/arpc_pkg.sv =====
// ----------------------------------------------------------------------------
// ARP cache package
// Table size, operation and opcode codes, and the entry and result types
// used by the cache engine; its storage takes only the entry width.
// ----------------------------------------------------------------------------
package arpc_pkg;

  // Number of IP to MAC bindings held in the table (2 to 256).
  localparam int TABLE_ENTRIES = 16;
  localparam int ADDR_W        = $clog2(TABLE_ENTRIES);

  // Operation codes of an input item.
  localparam logic [2:0] OP_LOOKUP  = 3'd0;
  localparam logic [2:0] OP_LEARN   = 3'd1;
  localparam logic [2:0] OP_RECEIVE = 3'd2;
  localparam logic [2:0] OP_READ    = 3'd3;
  localparam logic [2:0] OP_TICK    = 3'd4;

  // ARP packet operations.
  localparam logic [15:0] ARP_OP_REQUEST = 16'd1;
  localparam logic [15:0] ARP_OP_REPLY   = 16'd2;

  // One stored binding.
  typedef struct packed {
    logic [31:0] ip;
    logic [47:0] mac;
    logic [31:0] stamp;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // One result item.
  typedef struct packed {
    logic        hit;
    logic [47:0] mac;
    logic [31:0] ip;
    logic        valid;
    logic        index_error;
    logic        reply_needed;
    logic        notify_resolved;
  } result_t;

endpackage

// ===== rtl/arpc_ram.sv =====
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port; the read data is registered, so it
// appears in the cycle after the read address.
// ----------------------------------------------------------------------------
module arpc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/arp_cache_engine.sv =====
// ----------------------------------------------------------------------------
// ARP cache engine
// IP to MAC binding table with learn timestamps and oldest-entry replacement.
// ----------------------------------------------------------------------------
// The bindings live in one RAM with a single read port, and a lookup, learn
// or received packet scans every slot through that port, one slot a cycle,
// finding the matching IP, the first free slot and the oldest slot in the
// same pass. Such an item then passes through the drain, write and done
// states, and its result is offered once the output register is free; the
// next item can be accepted in the same cycle as that result is offered. A
// read by index passes through the read-wait and done states, and a tick,
// an out-of-range read, an ignored opcode or an unused operation goes
// straight to the done state. One item is worked on at a time, and the next
// item is accepted while the previous result still waits in the output
// register. Valid bits are held in flip-flops and are cleared by reset, so
// no clearing pass is needed; a slot that was never filled reads as zero.
module arp_cache_engine (
  input  logic        clk,
  input  logic        rst,
  // Configuration write channel.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data,
  // Input item channel.
  input  logic        req_valid,
  output logic        req_ready,
  input  logic [2:0]  operation,
  input  logic [31:0] ip_addr,
  input  logic [47:0] mac_addr,
  input  logic [31:0] target_ip,
  input  logic [15:0] arp_opcode,
  input  logic [7:0]  entry_index,
  // Result item channel.
  output logic        res_valid,
  input  logic        res_ready,
  output logic        hit,
  output logic [47:0] out_mac,
  output logic [31:0] out_ip,
  output logic        out_valid,
  output logic        index_error,
  output logic        reply_needed,
  output logic        notify_resolved
);

  localparam int AW = arpc_pkg::ADDR_W;
  localparam int N  = arpc_pkg::TABLE_ENTRIES;

  // Sequencer states.
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_DRAIN  = 3'd2;
  localparam logic [2:0] S_WRITE  = 3'd3;
  localparam logic [2:0] S_RDWAIT = 3'd4;
  localparam logic [2:0] S_DONE   = 3'd5;

  logic [2:0]  state;
  logic [2:0]  state_next;

  // Configuration and time.
  logic [31:0] own_ip;
  logic [31:0] tick_now;

  // Latched item.
  logic [2:0]  op_q;
  logic [31:0] ip_q;
  logic [47:0] mac_q;
  logic [31:0] tip_q;
  logic [15:0] opcode_q;
  logic [AW-1:0] idx_q;

  // Scan bookkeeping.
  logic [AW-1:0] scan_addr;
  logic          chk_vld;
  logic [AW-1:0] chk_idx;
  logic          found;
  logic [AW-1:0] match_idx;
  logic [47:0]   match_mac;
  logic          free_found;
  logic [AW-1:0] free_idx;
  logic          old_any;
  logic [AW-1:0] old_idx;
  logic [31:0]   old_stamp;

  logic [N-1:0]  valid;

  // RAM ports.
  logic                   rd_en;
  logic [AW-1:0]          rd_addr;
  arpc_pkg::entry_t       rd_entry;
  logic                   wr_en;
  logic [AW-1:0]          wr_addr;
  arpc_pkg::entry_t       wr_entry;

  // Result staging and output register.
  arpc_pkg::result_t fin;
  arpc_pkg::result_t fin_next;
  arpc_pkg::result_t res;

  logic req_fire;
  logic idx_ok;
  logic is_arp;
  logic reply_hit;
  logic out_free;

  assign req_ready = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign req_fire  = req_valid && req_ready;
  assign idx_ok    = ({1'b0, entry_index} < 9'(N));
  assign is_arp    = (arp_opcode == arpc_pkg::ARP_OP_REQUEST) ||
                     (arp_opcode == arpc_pkg::ARP_OP_REPLY);
  assign reply_hit = (opcode_q == arpc_pkg::ARP_OP_REQUEST) && (tip_q == own_ip);
  assign out_free  = !res_valid || res_ready;

  // Table storage.
  arpc_ram #(
    .WIDTH (arpc_pkg::ENTRY_W),
    .DEPTH (N)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_entry),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_entry)
  );

  // RAM access: scan reads, the indexed read, and the write-back.
  always_comb begin
    rd_en   = (state == S_SCAN) ||
              (req_fire && (operation == arpc_pkg::OP_READ) && idx_ok);
    rd_addr = (state == S_SCAN) ? scan_addr : entry_index[AW-1:0];
    wr_en   = (state == S_WRITE) && (op_q != arpc_pkg::OP_LOOKUP);
    if (found) begin
      wr_addr = match_idx;
    end else if (free_found) begin
      wr_addr = free_idx;
    end else begin
      wr_addr = old_idx;
    end
    wr_entry.ip    = ip_q;
    wr_entry.mac   = mac_q;
    wr_entry.stamp = tick_now;
  end

  // Next state and the result of finishing states.
  always_comb begin
    state_next = state;
    fin_next   = '0;
    unique case (state)
      S_IDLE: begin
        if (req_fire) begin
          case (operation)
            arpc_pkg::OP_LOOKUP, arpc_pkg::OP_LEARN: state_next = S_SCAN;
            arpc_pkg::OP_RECEIVE: state_next = is_arp ? S_SCAN : S_DONE;
            arpc_pkg::OP_READ: begin
              fin_next.index_error = !idx_ok;
              state_next = idx_ok ? S_RDWAIT : S_DONE;
            end
            default: state_next = S_DONE;
          endcase
        end
      end
      S_SCAN: begin
        if (scan_addr == AW'(N - 1)) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: state_next = S_WRITE;
      S_WRITE: begin
        state_next = S_DONE;
        case (op_q)
          arpc_pkg::OP_LOOKUP: begin
            fin_next.hit = found;
            fin_next.mac = found ? match_mac : 48'd0;
          end
          arpc_pkg::OP_LEARN: begin
            fin_next.notify_resolved = !found;
            fin_next.ip              = found ? 32'd0 : ip_q;
          end
          default: begin
            fin_next.reply_needed    = reply_hit;
            fin_next.notify_resolved = !found;
            fin_next.ip              = (reply_hit || !found) ? ip_q : 32'd0;
            fin_next.mac             = reply_hit ? mac_q : 48'd0;
          end
        endcase
      end
      S_RDWAIT: begin
        state_next     = S_DONE;
        fin_next.valid = valid[idx_q];
        fin_next.mac   = valid[idx_q] ? rd_entry.mac : 48'd0;
        fin_next.ip    = valid[idx_q] ? rd_entry.ip : 32'd0;
      end
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      own_ip    <= 32'd0;
      tick_now  <= 32'd0;
      valid     <= '0;
      chk_vld   <= 1'b0;
      res_valid <= 1'b0;
      scan_addr <= '0;
    end else begin
      state   <= state_next;
      chk_vld <= (state == S_SCAN);
      if (cfg_valid && cfg_ready) begin
        own_ip <= cfg_data;
      end
      if (req_fire && (operation == arpc_pkg::OP_TICK)) begin
        tick_now <= tick_now + 32'd1;
      end
      if (state == S_SCAN) begin
        scan_addr <= scan_addr + AW'(1);
      end else begin
        scan_addr <= '0;
      end
      if (wr_en && !found) begin
        valid[wr_addr] <= 1'b1;
      end
      if (state == S_DONE && out_free) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // Item fields, scan results and result payload.
  always_ff @(posedge clk) begin
    if (req_fire) begin
      op_q       <= operation;
      ip_q       <= ip_addr;
      mac_q      <= mac_addr;
      tip_q      <= target_ip;
      opcode_q   <= arp_opcode;
      idx_q      <= entry_index[AW-1:0];
      found      <= 1'b0;
      free_found <= 1'b0;
      old_any    <= 1'b0;
    end
    if (state == S_SCAN) begin
      chk_idx <= scan_addr;
    end
    // Check the slot whose data arrived this cycle.
    if (chk_vld) begin
      if (valid[chk_idx]) begin
        if (!found && rd_entry.ip == ip_q) begin
          found     <= 1'b1;
          match_idx <= chk_idx;
          match_mac <= rd_entry.mac;
        end
        if (!old_any || rd_entry.stamp < old_stamp) begin
          old_any   <= 1'b1;
          old_idx   <= chk_idx;
          old_stamp <= rd_entry.stamp;
        end
      end else if (!free_found) begin
        free_found <= 1'b1;
        free_idx   <= chk_idx;
      end
    end
    if (state != S_DONE) begin
      fin <= fin_next;
    end
    if (state == S_DONE && out_free) begin
      res <= fin;
    end
  end

  assign hit             = res.hit;
  assign out_mac         = res.mac;
  assign out_ip          = res.ip;
  assign out_valid       = res.valid;
  assign index_error     = res.index_error;
  assign reply_needed    = res.reply_needed;
  assign notify_resolved = res.notify_resolved;

  // Replacement of an old entry only happens when the table is full.
  a_full_on_replace: assert property (@(posedge clk) disable iff (rst)
    (wr_en && !found && !free_found) |-> (&valid))
    else $error("oldest entry replaced while a free slot exists");

  // Valid bits are never lost once set.
  a_valid_grows: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> ($countones(valid) >= $countones($past(valid))))
    else $error("valid bit cleared outside reset");

  // No scan data is still in flight when a new item may be accepted.
  a_idle_no_scan: assert property (@(posedge clk) disable iff (rst)
    req_ready |-> !chk_vld)
    else $error("new item accepted during a table scan");

  // An out-of-range read carries no other result.
  a_index_error_alone: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.index_error) |-> (!res.hit && !res.valid &&
      !res.notify_resolved && !res.reply_needed))
    else $error("index error combined with other result flags");

endmodule
